// ----- rtl/sfe_pkg.sv -----
// shared types, constants, microcode table and saturation helpers of the stereo echo
`timescale 1ns / 1ps

package sfe_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int LINE_AW     = 15;
    localparam int LINE_DEPTH  = 1 << LINE_AW;

    localparam int HIST_W  = 32;
    localparam int DIFF_W  = HIST_W + 1;
    localparam int PROD_W  = HIST_W + 2;
    localparam int ACC_W   = HIST_W + 3;
    localparam int COEF_W  = 17;
    localparam int RET_W   = 18;
    localparam int MUL_W   = DIFF_W + RET_W + 1;

    localparam int FRAC_BITS = 8;
    localparam int COEF_FRAC = 16;
    localparam int RET_SHIFT = FRAC_BITS + COEF_FRAC;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RET_W;

    localparam logic [COEF_W-1:0] UNITY_Q16  = COEF_W'(65536);
    localparam logic [RET_W-1:0]  RETURN_MAX = RET_W'(131072);

    localparam logic [LINE_AW-1:0] DELAY_RST = LINE_AW'(22500);
    localparam logic [COEF_W-1:0]  FB_RST    = COEF_W'(41943);
    localparam logic [COEF_W-1:0]  LPC_RST   = COEF_W'(8916);
    localparam logic [COEF_W-1:0]  HPC_RST   = COEF_W'(11889);
    localparam logic [RET_W-1:0]   RET_RST   = RET_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POWER = 3'd0,
        CFG_DELAY = 3'd1,
        CFG_FB    = 3'd2,
        CFG_LPC   = 3'd3,
        CFG_HPC   = 3'd4,
        CFG_RET   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [COEF_W-1:0] fb;
        logic [COEF_W-1:0] lp;
        logic [COEF_W-1:0] hp;
        logic [RET_W-1:0]  ret;
    } t_coefs;

    // lane operations
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_MUL       = 3'd1,
        OP_SUB_F_LP  = 3'd2,
        OP_ACC_LP    = 3'd3,
        OP_SUB_LP_HP = 3'd4,
        OP_ACC_HP    = 3'd5
    } t_lane_op;

    typedef enum logic {
        A_TAP  = 1'b0,
        A_DIFF = 1'b1
    } t_a_sel;

    typedef enum logic [1:0] {
        COEF_FB  = 2'd0,
        COEF_LP  = 2'd1,
        COEF_HP  = 2'd2,
        COEF_RET = 2'd3
    } t_coef_sel;

    typedef enum logic [1:0] {
        SH_8  = 2'd0,
        SH_16 = 2'd1,
        SH_24 = 2'd2
    } t_shift_sel;

    typedef enum logic [1:0] {
        COND_NEVER     = 2'd0,
        COND_NO_ITEM   = 2'd1,
        COND_POWER_OFF = 2'd2,
        COND_OUT_BUSY  = 2'd3
    } t_cond;

    typedef struct packed {
        t_lane_op   op;
        t_a_sel     a_sel;
        t_coef_sel  coef_sel;
        t_shift_sel shift_sel;
        logic       wr_calc;
    } t_lane_ctrl;

    typedef struct packed {
        logic take;
        logic fin_echo;
        logic fin_mute;
    } t_seq_stat;

    localparam int STEP_W = 4;

    typedef struct packed {
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              last;
        logic              take;
        logic              fin_echo;
        logic              fin_mute;
        t_lane_ctrl        lane;
    } t_uword;

    localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_FB   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SUB_FLP  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MUL_LP   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ACC_LP   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SUB_LH   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MUL_HP   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_ACC_HP   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SUB_E    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_MUL_RET  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd11;
    localparam logic [STEP_W-1:0] STEP_MUTE     = 4'd12;

    localparam t_uword UW_NOP = '{
        cond: COND_NEVER, target: STEP_IDLE, last: 1'b0, take: 1'b0,
        fin_echo: 1'b0, fin_mute: 1'b0,
        lane: '{op: OP_NONE, a_sel: A_TAP, coef_sel: COEF_FB, shift_sel: SH_8,
                wr_calc: 1'b0}
    };

    // microcode program, one control word per step
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = UW_NOP;
        unique case (step)
            STEP_IDLE: begin
                w.take   = 1'b1;
                w.cond   = COND_NO_ITEM;
                w.target = STEP_IDLE;
            end
            STEP_CHECK: begin
                w.cond   = COND_POWER_OFF;
                w.target = STEP_MUTE;
            end
            STEP_MUL_FB: begin
                w.lane.op        = OP_MUL;
                w.lane.a_sel     = A_TAP;
                w.lane.coef_sel  = COEF_FB;
                w.lane.shift_sel = SH_8;
            end
            STEP_SUB_FLP: w.lane.op = OP_SUB_F_LP;
            STEP_MUL_LP: begin
                w.lane.op        = OP_MUL;
                w.lane.a_sel     = A_DIFF;
                w.lane.coef_sel  = COEF_LP;
                w.lane.shift_sel = SH_16;
            end
            STEP_ACC_LP:  w.lane.op = OP_ACC_LP;
            STEP_SUB_LH:  w.lane.op = OP_SUB_LP_HP;
            STEP_MUL_HP: begin
                w.lane.op        = OP_MUL;
                w.lane.a_sel     = A_DIFF;
                w.lane.coef_sel  = COEF_HP;
                w.lane.shift_sel = SH_16;
            end
            STEP_ACC_HP:  w.lane.op = OP_ACC_HP;
            STEP_SUB_E:   w.lane.op = OP_SUB_LP_HP;
            STEP_MUL_RET: begin
                w.lane.op        = OP_MUL;
                w.lane.a_sel     = A_DIFF;
                w.lane.coef_sel  = COEF_RET;
                w.lane.shift_sel = SH_24;
                w.lane.wr_calc   = 1'b1;
            end
            STEP_FINISH: begin
                w.cond     = COND_OUT_BUSY;
                w.target   = STEP_FINISH;
                w.last     = 1'b1;
                w.fin_echo = 1'b1;
            end
            STEP_MUTE: begin
                w.cond     = COND_OUT_BUSY;
                w.target   = STEP_MUTE;
                w.last     = 1'b1;
                w.fin_mute = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [PROD_W-1:0] v
    );
        logic [PROD_W-SAMPLE_BITS:0] hi;
        hi = v[PROD_W-1:SAMPLE_BITS-1];
        if (hi == '0 || hi == '1) begin
            return v[SAMPLE_BITS-1:0];
        end else if (v[PROD_W-1]) begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [HIST_W-1:0] sat_hist(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-HIST_W:0] hi;
        hi = v[ACC_W-1:HIST_W-1];
        if (hi == '0 || hi == '1) begin
            return v[HIST_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(HIST_W-1){1'b0}}};
        end else begin
            return {1'b0, {(HIST_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- rtl/stereo_feedback_echo_unit.sv -----
// top level of the stereo feedback echo: configuration, handshakes and unit wiring
`timescale 1ns / 1ps

// Stereo feedback echo with damping. Each accepted item (one 24-bit stereo pair)
// reads both delay lines at write position plus one minus delay_samples, runs the
// tap through feedback gain, a one-pole low-pass and a one-pole high-pass, writes
// filtered echo plus input back with saturation and returns the echo scaled by
// return_gain. A small microcode program steps one multiplier per channel through
// the four products and the history updates; with power off an item skips them
// and gives a zero result. A result waits while the previous one is still
// stalled at the output. One item is in work at a time; a new item is taken as
// soon as the previous result is in the output register. Both lines share one
// 32768 x 48 memory, read once per item and written once per item with power on.
// After reset or a write of power_on = 0 no clearing pass runs: the write position
// and a wrap flag mark which entries were written, and taps of older entries read
// as zero, so items are accepted at once. Configuration must be written only while
// no item is in work; the block itself does not enforce this. Coefficients above
// their range are clamped on write, the filter and feedback ones on their low 17 bits.
module stereo_feedback_echo_unit import sfe_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out
);

    logic               r_power;
    logic [LINE_AW-1:0] r_delay;
    logic [COEF_W-1:0]  r_fb;
    logic [COEF_W-1:0]  r_lpc;
    logic [COEF_W-1:0]  r_hpc;
    logic [RET_W-1:0]   r_ret;

    logic signed [SAMPLE_BITS-1:0] r_left_in;
    logic signed [SAMPLE_BITS-1:0] r_right_in;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;

    logic [COEF_W-1:0]          w_coef_in;
    logic [RET_W-1:0]           w_ret_in;
    logic                       w_clear;
    logic                       w_accept;
    logic                       w_out_busy;
    t_coefs                     w_coefs;
    t_lane_ctrl                 w_lane;
    t_seq_stat                  w_stat;
    logic [2*SAMPLE_BITS-1:0]   w_rd_data;
    logic [2*SAMPLE_BITS-1:0]   w_wr_data;
    logic signed [SAMPLE_BITS-1:0] w_wr_left;
    logic signed [SAMPLE_BITS-1:0] w_wr_right;
    logic signed [SAMPLE_BITS-1:0] w_echo_left;
    logic signed [SAMPLE_BITS-1:0] w_echo_right;

    assign w_coef_in = (i_cfg_data[COEF_W-1:0] > UNITY_Q16) ? UNITY_Q16
                                                           : i_cfg_data[COEF_W-1:0];
    assign w_ret_in  = (i_cfg_data > RETURN_MAX) ? RETURN_MAX : i_cfg_data;
    // power-off write resets histories, write position and wrap flag, even if already off
    assign w_clear   = i_cfg_we && (i_cfg_index == CFG_POWER) && !i_cfg_data[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= 1'b0;
            r_delay <= DELAY_RST;
            r_fb    <= FB_RST;
            r_lpc   <= LPC_RST;
            r_hpc   <= HPC_RST;
            r_ret   <= RET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POWER: r_power <= i_cfg_data[0];
                CFG_DELAY: r_delay <= i_cfg_data[LINE_AW-1:0];
                CFG_FB:    r_fb    <= w_coef_in;
                CFG_LPC:   r_lpc   <= w_coef_in;
                CFG_HPC:   r_hpc   <= w_coef_in;
                CFG_RET:   r_ret   <= w_ret_in;
                default: begin
                end
            endcase
        end
    end

    assign w_coefs.fb  = r_fb;
    assign w_coefs.lp  = r_lpc;
    assign w_coefs.hp  = r_hpc;
    assign w_coefs.ret = r_ret;

    assign o_in_stall = !w_stat.take;
    assign w_accept   = i_in_valid && w_stat.take;
    assign w_out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left_in  <= i_left_in;
            r_right_in <= i_right_in;
        end
    end

    sfe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_power    (r_power),
        .i_out_busy (w_out_busy),
        .o_lane     (w_lane),
        .o_stat     (w_stat)
    );

    assign w_wr_data = {w_wr_left, w_wr_right};

    sfe_line u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_rd_en   (w_accept),
        .i_delay   (r_delay),
        .i_wr_en   (w_stat.fin_echo),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    sfe_lane u_lane_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_ctrl    (w_lane),
        .i_coefs   (w_coefs),
        .i_tap     ($signed(w_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .i_sample  (r_left_in),
        .o_wr_data (w_wr_left),
        .o_echo    (w_echo_left)
    );

    sfe_lane u_lane_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_ctrl    (w_lane),
        .i_coefs   (w_coefs),
        .i_tap     ($signed(w_rd_data[SAMPLE_BITS-1:0])),
        .i_sample  (r_right_in),
        .o_wr_data (w_wr_right),
        .o_echo    (w_echo_right)
    );

    // output register parts the result from the next item's work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.fin_echo || w_stat.fin_mute) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.fin_echo) begin
            r_left_out  <= w_echo_left;
            r_right_out <= w_echo_right;
        end else if (w_stat.fin_mute) begin
            r_left_out  <= '0;
            r_right_out <= '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

// ----- rtl/sfe_seq.sv -----
// microcode sequencer: step counter, control rom and conditional jumps
`timescale 1ns / 1ps

module sfe_seq import sfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_power,
    input  logic       i_out_busy,
    output t_lane_ctrl o_lane,
    output t_seq_stat  o_stat
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w_uw;
    logic              w_jump;

    assign w_uw = ucode(r_step);

    always_comb begin
        unique case (w_uw.cond)
            COND_NEVER:     w_jump = 1'b0;
            COND_NO_ITEM:   w_jump = !i_in_valid;
            COND_POWER_OFF: w_jump = !i_power;
            COND_OUT_BUSY:  w_jump = i_out_busy;
            default:        w_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (w_jump) begin
            n_step = w_uw.target;
        end else if (w_uw.last) begin
            n_step = STEP_IDLE;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_lane          = w_uw.lane;
    assign o_stat.take     = w_uw.take;
    // finishing actions only fire on the cycle the step is left
    assign o_stat.fin_echo = w_uw.fin_echo && !w_jump;
    assign o_stat.fin_mute = w_uw.fin_mute && !w_jump;

endmodule

// ----- rtl/sfe_lane.sv -----
// one channel of the echo datapath: shared multiplier, filter histories, write-back value
`timescale 1ns / 1ps

module sfe_lane import sfe_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  t_lane_ctrl                    i_ctrl,
    input  t_coefs                        i_coefs,
    input  logic signed [SAMPLE_BITS-1:0] i_tap,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_wr_data,
    output logic signed [SAMPLE_BITS-1:0] o_echo
);

    logic signed [HIST_W-1:0]      r_lp;
    logic signed [HIST_W-1:0]      r_hp;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [DIFF_W-1:0]      r_diff;
    logic signed [SAMPLE_BITS-1:0] r_wr;

    logic [RET_W-1:0]         w_coef;
    logic signed [RET_W:0]    w_b;
    logic signed [DIFF_W-1:0] w_a;
    logic signed [MUL_W-1:0]  w_mul;
    logic signed [MUL_W-1:0]  w_sh;
    logic signed [HIST_W-1:0] w_f;
    logic signed [PROD_W-1:0] w_wsum;

    always_comb begin
        unique case (i_ctrl.coef_sel)
            COEF_FB:  w_coef = RET_W'(i_coefs.fb);
            COEF_LP:  w_coef = RET_W'(i_coefs.lp);
            COEF_HP:  w_coef = RET_W'(i_coefs.hp);
            COEF_RET: w_coef = i_coefs.ret;
            default:  w_coef = i_coefs.ret;
        endcase
    end

    assign w_b   = $signed({1'b0, w_coef});
    assign w_a   = (i_ctrl.a_sel == A_TAP) ? DIFF_W'(i_tap) : r_diff;
    assign w_mul = MUL_W'(w_a) * MUL_W'(w_b);

    // arithmetic shifts round toward minus infinity
    always_comb begin
        unique case (i_ctrl.shift_sel)
            SH_8:    w_sh = w_mul >>> FRAC_BITS;
            SH_16:   w_sh = w_mul >>> COEF_FRAC;
            SH_24:   w_sh = w_mul >>> RET_SHIFT;
            default: w_sh = w_mul >>> RET_SHIFT;
        endcase
    end

    // feedback product fits the history width
    assign w_f    = $signed(r_prod[HIST_W-1:0]);
    assign w_wsum = PROD_W'(r_diff >>> FRAC_BITS) + PROD_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_lp <= '0;
            r_hp <= '0;
        end else begin
            unique case (i_ctrl.op)
                OP_ACC_LP: r_lp <= sat_hist(ACC_W'(r_lp) + ACC_W'(r_prod));
                OP_ACC_HP: r_hp <= sat_hist(ACC_W'(r_hp) + ACC_W'(r_prod));
                OP_NONE, OP_MUL, OP_SUB_F_LP, OP_SUB_LP_HP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            OP_MUL:       r_prod <= w_sh[PROD_W-1:0];
            OP_SUB_F_LP:  r_diff <= DIFF_W'(w_f) - DIFF_W'(r_lp);
            OP_SUB_LP_HP: r_diff <= DIFF_W'(r_lp) - DIFF_W'(r_hp);
            OP_NONE, OP_ACC_LP, OP_ACC_HP: begin
            end
            default: begin
            end
        endcase
        if (i_ctrl.wr_calc) begin
            r_wr <= sat_sample(w_wsum);
        end
    end

    assign o_wr_data = r_wr;
    assign o_echo    = sat_sample(r_prod);

endmodule

// ----- rtl/sfe_line.sv -----
// stereo delay memory with write position and fill tracking in place of a clearing pass
`timescale 1ns / 1ps

module sfe_line import sfe_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_rd_en,
    input  logic [LINE_AW-1:0]         i_delay,
    input  logic                       i_wr_en,
    input  logic [2*SAMPLE_BITS-1:0]   i_wr_data,
    output logic [2*SAMPLE_BITS-1:0]   o_rd_data
);

    logic [2*SAMPLE_BITS-1:0] mem [LINE_DEPTH];

    logic [LINE_AW-1:0]       r_pos;
    logic                     r_full;
    logic [2*SAMPLE_BITS-1:0] r_rd_data;
    logic                     r_rd_ok;

    logic [LINE_AW-1:0] w_pos_next;
    logic [LINE_AW-1:0] w_tap;
    logic               w_tap_ok;

    assign w_pos_next = r_pos + LINE_AW'(1);
    assign w_tap      = w_pos_next - i_delay;
    // since the last clear only positions one through r_pos hold data, until the wrap
    assign w_tap_ok   = r_full || (w_tap != '0 && w_tap <= r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pos  <= '0;
            r_full <= 1'b0;
        end else if (i_wr_en) begin
            r_pos <= w_pos_next;
            if (w_pos_next == '0) begin
                r_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[w_pos_next] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[w_tap];
            r_rd_ok   <= w_tap_ok;
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule
